// ===== src/gage_pkg.sv =====
// ----------------------------------------------------------------------------
// gage_pkg
// shared constants, types and helpers for the generation engine
// ----------------------------------------------------------------------------
package gage_pkg;

  localparam int POP_DEPTH = 128;
  localparam int GENE_BITS = 16;

  localparam int SLOT_W  = $clog2(POP_DEPTH);
  localparam int IDX_W   = $clog2(POP_DEPTH + 1);
  localparam int ADDR_W  = SLOT_W + 1;
  localparam int MEM_DEPTH = 2 * POP_DEPTH;
  localparam int FIT_W   = $clog2(GENE_BITS + 1);
  localparam int TOTAL_W = FIT_W + SLOT_W;
  localparam int PICK_W  = 16;
  localparam int PROD_W  = PICK_W + TOTAL_W;
  localparam int CUT_W   = 4;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int POP_CFG_W  = 8;
  localparam int LEN_CFG_W  = 5;

  localparam logic [POP_CFG_W-1:0] POP_COUNT_RESET = 8'd100;
  localparam logic [LEN_CFG_W-1:0] GENE_LEN_RESET  = 5'd10;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BREED  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENE_LEN  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_TARGET,
    ST_PICK,
    ST_GENE_A,
    ST_GENE_B,
    ST_CHILD,
    ST_COMMIT_RD,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  function automatic logic [FIT_W-1:0] ones_in(input logic [GENE_BITS-1:0] v);
    logic [FIT_W-1:0] c;
    c = '0;
    for (int i = 0; i < GENE_BITS; i++) begin
      c = c + FIT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

// ===== src/genetic_algorithm_generation_engine.sv =====
// ----------------------------------------------------------------------------
// genetic_algorithm_generation_engine
// one generation step of a bit-string genetic algorithm with roulette pick
// ----------------------------------------------------------------------------
// Two banks of POP_DEPTH genes and their ones counts live in a pair of
// synchronous memories with one read and one write port each (one for
// genes, one for fitness), with the current bank chosen by a flag. A load
// beat writes a masked gene into the current bank; its result is loaded
// from the finish state once the output register is free. A breed beat
// walks the fitness memory once to form the total, once more to pick both
// parents in the same pass, then reads the two parent genes one after the
// other and forms the child before its result is loaded the same way, as
// is a commit beat's result after its read of the other bank. The next
// input beat can be taken in the cycle after the result is loaded.
// One beat is worked at a time; input stall is high from accept until the
// result is loaded into the output register, and a result waiting on output
// stall does not hold up the next input beat once it is loaded. The store
// has no reset and no clearing pass: a slot that was never written reads
// back as garbage. The configuration port is always ready and must only be
// written when no beat is in flight.
module genetic_algorithm_generation_engine
  import gage_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [GENE_BITS-1:0]  gene,
  input  logic [PICK_W-1:0]     pick_first,
  input  logic [PICK_W-1:0]     pick_second,
  input  logic [CUT_W-1:0]      cut,
  input  logic [GENE_BITS-1:0]  flip_mask,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GENE_BITS-1:0]  child_gene,
  output logic [FIT_W-1:0]      child_fitness,
  output logic [SLOT_W-1:0]     first_parent,
  output logic [SLOT_W-1:0]     second_parent,
  output logic                  optimum_found,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // gene and fitness memories, bank in the top address bit
  logic [GENE_BITS-1:0] gene_mem [MEM_DEPTH];
  logic [FIT_W-1:0]     fit_mem  [MEM_DEPTH];
  logic [GENE_BITS-1:0] gene_rd;
  logic [FIT_W-1:0]     fit_rd;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_en;

  // control state
  state_t               state, state_next;
  logic                 cur_bank;
  logic [POP_CFG_W-1:0] pop_count;
  logic [LEN_CFG_W-1:0] gene_len;
  logic                 out_load;

  // per-beat working registers
  logic [SLOT_W-1:0]    slot_q;
  logic                 wr_bank;
  logic                 wr_pend;
  logic [PICK_W-1:0]    pick_a, pick_b;
  logic [CUT_W-1:0]     cut_q;
  logic [GENE_BITS-1:0] flip_q;
  logic [IDX_W-1:0]     idx;
  logic [TOTAL_W-1:0]   total, sum;
  logic [TOTAL_W-1:0]   target_a, target_b;
  logic                 found_a, found_b;
  logic [SLOT_W-1:0]    par_a, par_b;
  logic [GENE_BITS-1:0] gene_a;
  logic [GENE_BITS-1:0] res_gene;
  logic                 res_opt;

  // clamped configuration and masks
  logic [IDX_W-1:0]     n_used;
  logic [LEN_CFG_W-1:0] bits_used;
  logic [GENE_BITS:0]   mask_wide, low_wide;
  logic [GENE_BITS-1:0] mask, low;
  logic [TOTAL_W-1:0]   sum_step;
  logic [PROD_W-1:0]    prod_a, prod_b;
  logic [GENE_BITS-1:0] gene_masked;
  logic                 last_walk;

  always_comb begin
    if (pop_count == '0) begin
      n_used = IDX_W'(1);
    end else if (IDX_W'(pop_count) > IDX_W'(POP_DEPTH)) begin
      n_used = IDX_W'(POP_DEPTH);
    end else begin
      n_used = IDX_W'(pop_count);
    end
    if (gene_len == '0) begin
      bits_used = LEN_CFG_W'(1);
    end else if (gene_len > LEN_CFG_W'(GENE_BITS)) begin
      bits_used = LEN_CFG_W'(GENE_BITS);
    end else begin
      bits_used = gene_len;
    end
  end

  assign mask_wide   = ((GENE_BITS + 1)'(1) << bits_used) - (GENE_BITS + 1)'(1);
  assign mask        = mask_wide[GENE_BITS-1:0];
  assign low_wide    = ((GENE_BITS + 1)'(1) << cut_q) - (GENE_BITS + 1)'(1);
  assign low         = low_wide[GENE_BITS-1:0];
  assign sum_step    = sum + TOTAL_W'(fit_rd);
  assign prod_a      = PROD_W'(pick_a) * PROD_W'(total);
  assign prod_b      = PROD_W'(pick_b) * PROD_W'(total);
  assign gene_masked = gene_rd & mask;
  assign last_walk   = (idx == n_used);
  assign wr_addr     = {wr_bank, slot_q};

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // memories: one read and one write port each, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      gene_mem[wr_addr] <= res_gene;
      fit_mem[wr_addr]  <= ones_in(res_gene);
    end
    gene_rd <= gene_mem[rd_addr];
    fit_rd  <= fit_mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, read address and write strobe
  always_comb begin
    state_next = state;
    rd_addr    = {cur_bank, idx[SLOT_W-1:0]};
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_LOAD:   state_next = ST_FINISH;
            OP_BREED:  state_next = ST_SUM;
            OP_COMMIT: state_next = ST_COMMIT_RD;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_SUM: begin
        if (last_walk) state_next = ST_TARGET;
      end
      ST_TARGET: state_next = ST_PICK;
      ST_PICK: begin
        if (last_walk) state_next = ST_GENE_A;
      end
      ST_GENE_A: begin
        rd_addr    = {cur_bank, par_a};
        state_next = ST_GENE_B;
      end
      ST_GENE_B: begin
        rd_addr    = {cur_bank, par_b};
        state_next = ST_CHILD;
      end
      ST_CHILD: state_next = ST_FINISH;
      ST_COMMIT_RD: begin
        rd_addr    = {~cur_bank, SLOT_W'(0)};
        state_next = ST_COMMIT;
      end
      ST_COMMIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          wr_en      = wr_pend;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank  <= 1'b0;
      pop_count <= POP_COUNT_RESET;
      gene_len  <= GENE_LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POP_COUNT: pop_count <= cfg_data[POP_CFG_W-1:0];
          CFG_GENE_LEN:  gene_len  <= cfg_data[LEN_CFG_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_COMMIT) cur_bank <= ~cur_bank;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          slot_q   <= slot;
          pick_a   <= pick_first;
          pick_b   <= pick_second;
          cut_q    <= cut;
          flip_q   <= flip_mask;
          idx      <= '0;
          total    <= '0;
          par_a    <= '0;
          par_b    <= '0;
          res_opt  <= 1'b0;
          // load echoes the masked gene, breed fills it in later
          res_gene <= (op == OP_LOAD) ? (gene & mask) : '0;
          wr_pend  <= (op == OP_LOAD) || (op == OP_BREED);
          // load writes the current bank, breed the next one
          wr_bank  <= (op == OP_LOAD) ? cur_bank : ~cur_bank;
        end
      end
      ST_SUM: begin
        // read data is registered, so it trails the address
        if (idx != '0) total <= total + TOTAL_W'(fit_rd);
        idx <= last_walk ? '0 : idx + IDX_W'(1);
      end
      ST_TARGET: begin
        target_a <= prod_a[PROD_W-1:PICK_W];
        target_b <= prod_b[PROD_W-1:PICK_W];
        sum      <= '0;
        found_a  <= 1'b0;
        found_b  <= 1'b0;
        par_a    <= SLOT_W'(n_used - IDX_W'(1));
        par_b    <= SLOT_W'(n_used - IDX_W'(1));
      end
      ST_PICK: begin
        // both wheels spin in one pass, first slot reaching its target wins
        if (idx != '0) begin
          sum <= sum_step;
          if (!found_a && sum_step >= target_a) begin
            found_a <= 1'b1;
            par_a   <= SLOT_W'(idx - IDX_W'(1));
          end
          if (!found_b && sum_step >= target_b) begin
            found_b <= 1'b1;
            par_b   <= SLOT_W'(idx - IDX_W'(1));
          end
        end
        idx <= idx + IDX_W'(1);
      end
      ST_GENE_B: gene_a <= gene_rd;
      ST_CHILD: begin
        res_gene <= (((gene_a & low) | (gene_rd & ~low)) ^ flip_q) & mask;
      end
      ST_COMMIT: begin
        res_gene <= gene_masked;
        res_opt  <= (gene_masked == mask);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      child_gene    <= res_gene;
      child_fitness <= ones_in(res_gene);
      first_parent  <= par_a;
      second_parent <= par_b;
      optimum_found <= res_opt;
    end
  end

`ifndef SYNTHESIS
  // a pending result names parents inside the slots in use
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (IDX_W'(first_parent) < n_used) && (IDX_W'(second_parent) < n_used))
    else $error("parent slot beyond population");

  // result fitness never exceeds the gene length in use
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (child_fitness <= FIT_W'(bits_used)))
    else $error("fitness exceeds gene length");

  // banks swap only on commit
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_COMMIT) |=> (cur_bank == $past(cur_bank)))
    else $error("bank swapped outside commit");

  // the store is only written while a result is handed to the output register
  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> out_valid && (state == ST_IDLE))
    else $error("store write without result");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the genetic algorithm generation engine
// ----------------------------------------------------------------------------
// A short table of directed beats runs first: the reset gene mask, an unused
// opcode, the top slot, breeds at both pick extremes, a zero-fitness wheel,
// a cut past the gene length, and commits that hit the all-ones case.
// Random phases then walk whole generations: fill the current bank, breed a
// full brood, commit, with stray loads, stray breeds, early commits and dead
// opcodes mixed in. Every result is compared with a software copy of the
// engine that tracks both banks, the bank flag and the two registers.
// ----------------------------------------------------------------------------
module tb;
  import gage_pkg::*;

  // opcode the engine treats as a no-op, and a register index with no register
  localparam logic [OP_W-1:0]      OP_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int RANDOM_BEATS  = 1500;
  localparam int QUIET_LIMIT   = 4000;  // covers the worst breed plus stalls
  localparam int SETTLE_CYCLES = 300;
  localparam int PLAN_ROWS     = 23;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    slot;
    logic [GENE_BITS-1:0] gene;
    logic [PICK_W-1:0]    pick_a;
    logic [PICK_W-1:0]    pick_b;
    logic [CUT_W-1:0]     cut;
    logic [GENE_BITS-1:0] flip;
  } ga_beat_t;

  typedef struct packed {
    logic [GENE_BITS-1:0] gene;
    logic [FIT_W-1:0]     fit;
    logic [SLOT_W-1:0]    pa;
    logic [SLOT_W-1:0]    pb;
    logic                 opt;
  } ga_reply_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    ga_beat_t              beat;
    logic                  fixed;  // reply typed in below, else from the predictor
    ga_reply_t             reply;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       op;
  logic [SLOT_W-1:0]     slot;
  logic [GENE_BITS-1:0]  gene;
  logic [PICK_W-1:0]     pick_first;
  logic [PICK_W-1:0]     pick_second;
  logic [CUT_W-1:0]      cut;
  logic [GENE_BITS-1:0]  flip_mask;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [GENE_BITS-1:0]  child_gene;
  logic [FIT_W-1:0]      child_fitness;
  logic [SLOT_W-1:0]     first_parent;
  logic [SLOT_W-1:0]     second_parent;
  logic                  optimum_found;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the engine: both banks, the bank flag and the registers
  logic [GENE_BITS-1:0] gene_mem [MEM_DEPTH];
  logic [FIT_W-1:0]     fit_mem  [MEM_DEPTH];
  bit                   written  [MEM_DEPTH];
  bit                   bank_sel = 1'b0;
  logic [POP_CFG_W-1:0] pop_reg  = POP_COUNT_RESET;
  logic [LEN_CFG_W-1:0] len_reg  = GENE_LEN_RESET;

  ga_reply_t   replies_due [$];
  int          faults     = 0;
  bit          idle_on    = 1'b1;
  int unsigned brood_slot = 0;
  int unsigned stall_hold = 0;
  int unsigned quiet      = 0;

  // directed beats; the reply is typed in only where it is plain to see
  plan_row_t plan [PLAN_ROWS] = '{
    // reset gene_len of 10 masks the load
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd0, 16'hFFFF, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '{16'h03FF, 5'd10, 7'd0, 7'd0, 1'b0}},
    // dead opcode with every field high gives an all-zero reply
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_NONE, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF},
      1'b1, '0},
    // top slot, outside the population in use
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'h7F, 16'h0, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '0},
    '{1'b1, CFG_POP_COUNT, 8'd4, '0, 1'b0, '0},
    '{1'b1, CFG_GENE_LEN, 8'd16, '0, 1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd0, 16'hFFFF, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '{16'hFFFF, 5'd16, 7'd0, 7'd0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd1, 16'h0000, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd2, 16'hA5A5, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '{16'hA5A5, 5'd8, 7'd0, 7'd0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd3, 16'h8001, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '{16'h8001, 5'd2, 7'd0, 7'd0, 1'b0}},
    // breeds at both ends of the wheel and of the cut
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd0, 16'h0, 16'h0000, 16'h0000, 4'd8, 16'h0},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd1, 16'h0, 16'hFFFF, 16'hFFFF, 4'd0, 16'hFFFF},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd2, 16'h0, 16'h8000, 16'h4000, 4'd15, 16'h0},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd3, 16'h0, 16'h1234, 16'hC000, 4'd7, 16'h0F0F},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_COMMIT, 7'd0, 16'h0, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'h7F, 16'h0, 16'hFFFF, 16'h0001, 4'd4, 16'h8000},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_COMMIT, 7'd0, 16'h0, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b0, '0},
    '{1'b1, CFG_POP_COUNT, 8'd2, '0, 1'b0, '0},
    '{1'b1, CFG_GENE_LEN, 8'd4, '0, 1'b0, '0},
    // two zero genes in use: the wheel has no fitness at all
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd0, 16'hFFF0, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_LOAD, 7'd1, 16'h0000, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b1, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd0, 16'h0, 16'hFFFF, 16'hFFFF, 4'd2, 16'hFFFF},
      1'b0, '0},
    // cut beyond the gene length
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_BREED, 7'd1, 16'h0, 16'h0, 16'h0, 4'd15, 16'h0},
      1'b0, '0},
    '{1'b0, CFG_POP_COUNT, 8'd0, '{OP_COMMIT, 7'd0, 16'h0, 16'h0, 16'h0, 4'd0, 16'h0},
      1'b0, '0}
  };

  genetic_algorithm_generation_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .slot          (slot),
    .gene          (gene),
    .pick_first    (pick_first),
    .pick_second   (pick_second),
    .cut           (cut),
    .flip_mask     (flip_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .child_gene    (child_gene),
    .child_fitness (child_fitness),
    .first_parent  (first_parent),
    .second_parent (second_parent),
    .optimum_found (optimum_found),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // registers are clamped into range where they are used
  function automatic int unsigned live_slots();
    if (pop_reg == 0) return 1;
    if (pop_reg > POP_DEPTH) return POP_DEPTH;
    return pop_reg;
  endfunction

  function automatic int unsigned live_bits();
    if (len_reg == 0) return 1;
    if (len_reg > GENE_BITS) return GENE_BITS;
    return len_reg;
  endfunction

  function automatic logic [GENE_BITS-1:0] live_mask();
    return GENE_BITS'((32'd1 << live_bits()) - 32'd1);
  endfunction

  function automatic void put_gene(int unsigned addr, logic [GENE_BITS-1:0] g);
    gene_mem[addr] = g;
    fit_mem[addr]  = FIT_W'($countones(g));
    written[addr]  = 1'b1;
  endfunction

  // first slot whose running fitness reaches pick/65536 of the total
  function automatic int unsigned spin_wheel(int unsigned base, int unsigned n,
                                             logic [PICK_W-1:0] pick);
    longint unsigned total;
    longint unsigned run;
    longint unsigned aim;
    int unsigned     i;
    total = 0;
    run   = 0;
    for (i = 0; i < n; i++) total += fit_mem[base + i];
    aim = (64'(pick) * total) >> 16;
    for (i = 0; i < n; i++) begin
      run += fit_mem[base + i];
      if (run >= aim) return i;
    end
    return n - 1;
  endfunction

  // one beat through the shadow engine; updates the banks and the bank flag
  function automatic ga_reply_t ga_step(ga_beat_t b);
    ga_reply_t            r;
    int unsigned          cur;
    int unsigned          nxt;
    int unsigned          pa;
    int unsigned          pb;
    logic [GENE_BITS-1:0] keep;
    logic [GENE_BITS-1:0] low;
    logic [GENE_BITS-1:0] g;
    r    = '0;
    cur  = int'(bank_sel) * POP_DEPTH;
    nxt  = int'(!bank_sel) * POP_DEPTH;
    keep = live_mask();
    case (b.op)
      OP_LOAD: begin
        g = b.gene & keep;
        put_gene(cur + b.slot, g);
        r.gene = g;
        r.fit  = FIT_W'($countones(g));
      end
      OP_BREED: begin
        pa  = spin_wheel(cur, live_slots(), b.pick_a);
        pb  = spin_wheel(cur, live_slots(), b.pick_b);
        low = GENE_BITS'((32'd1 << b.cut) - 32'd1);
        g   = (((gene_mem[cur + pa] & low) | (gene_mem[cur + pb] & ~low)) ^ b.flip) & keep;
        put_gene(nxt + b.slot, g);
        r.gene = g;
        r.fit  = FIT_W'($countones(g));
        r.pa   = SLOT_W'(pa);
        r.pb   = SLOT_W'(pb);
      end
      OP_COMMIT: begin
        bank_sel = !bank_sel;
        g        = gene_mem[nxt] & keep;
        r.gene   = g;
        r.fit    = FIT_W'($countones(g));
        r.opt    = (g == keep);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned burst_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // mostly whole generations (fill, breed a full brood, commit), some noise;
  // never reads a slot of either bank that has not been written
  function automatic ga_beat_t plan_next_beat();
    ga_beat_t    b;
    int unsigned n;
    int unsigned cur;
    int unsigned nxt;
    int          hole;
    int          i;
    int unsigned roll;
    n    = live_slots();
    cur  = int'(bank_sel) * POP_DEPTH;
    nxt  = int'(!bank_sel) * POP_DEPTH;
    hole = -1;
    for (i = int'(n) - 1; i >= 0; i--) if (!written[cur + i]) hole = i;
    b.op     = OP_LOAD;
    b.slot   = SLOT_W'($urandom);
    b.gene   = ($urandom_range(0, 7) == 0) ? {GENE_BITS{1'b1}} : GENE_BITS'($urandom);
    b.pick_a = PICK_W'($urandom);
    b.pick_b = PICK_W'($urandom);
    b.cut    = CUT_W'($urandom);
    // sparse mutation most of the time, a full random mask now and then
    if ($urandom_range(0, 3) == 0) b.flip = GENE_BITS'($urandom);
    else if ($urandom_range(0, 1) == 0) b.flip = GENE_BITS'(1) << $urandom_range(0, GENE_BITS - 1);
    else b.flip = '0;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      b.op = OP_NONE;
    end else if (roll < 8) begin
      b.op = OP_LOAD;                       // stray load, any slot
    end else if (roll < 11 && hole < 0) begin
      b.op = OP_BREED;                      // stray child, any slot
    end else if (roll < 13 && written[nxt]) begin
      b.op       = OP_COMMIT;               // early commit, brood unfinished
      brood_slot = 0;
    end else if (hole >= 0) begin
      b.op   = OP_LOAD;
      b.slot = SLOT_W'(hole);
    end else if (brood_slot < n) begin
      b.op       = OP_BREED;
      b.slot     = SLOT_W'(brood_slot);
      brood_slot = brood_slot + 1;
    end else begin
      b.op       = OP_COMMIT;
      brood_slot = 0;
    end
    return b;
  endfunction

  // present one beat, hold it until taken, then maybe leave a gap
  task automatic offer(input ga_beat_t b, input bit fixed, input ga_reply_t reply);
    ga_reply_t   r;
    int unsigned gap;
    in_valid    <= 1'b1;
    op          <= b.op;
    slot        <= b.slot;
    gene        <= b.gene;
    pick_first  <= b.pick_a;
    pick_second <= b.pick_b;
    cut         <= b.cut;
    flip_mask   <= b.flip;
    do @(posedge clk); while (in_stall);
    r = ga_step(b);
    replies_due.push_back(fixed ? reply : r);
    gap = idle_on ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every reply is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // keep cfg_valid up when another write follows straight away
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POP_COUNT) pop_reg = val;
    else if (idx == CFG_GENE_LEN) len_reg = val[LEN_CFG_W-1:0];
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h, got %h", $time, what, want, got);
      faults++;
    end
  endtask

  // result side: each accepted beat is matched with the oldest awaited reply
  always @(posedge clk) begin
    ga_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t child_gene: expected nothing, got %h", $time, child_gene);
        faults++;
      end else begin
        want = replies_due.pop_front();
        compare_field("child_gene", want.gene, child_gene);
        compare_field("child_fitness", 16'(want.fit), 16'(child_fitness));
        compare_field("first_parent", 16'(want.pa), 16'(first_parent));
        compare_field("second_parent", 16'(want.pb), 16'(second_parent));
        compare_field("optimum_found", 16'(want.opt), 16'(optimum_found));
      end
    end
  end

  // result stall in bursts: mostly short, sometimes long, off in quiet phases
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= idle_on && ($urandom_range(0, 2) == 0);
      stall_hold <= burst_len();
    end
  end

  // watchdog: too long with no beat moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("genetic_algorithm_generation_engine: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          r;
    int unsigned phase;
    int unsigned quota;
    int unsigned random_beats;
    logic [7:0]  pop_val;
    logic [7:0]  len_val;
    ga_beat_t    b;

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_LOAD;
    slot        <= '0;
    gene        <= '0;
    pick_first  <= '0;
    pick_second <= '0;
    cut         <= '0;
    flip_mask   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_POP_COUNT;
    cfg_data    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table; registers change only once the engine has gone quiet
    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_cfg) begin
        if (r == 0 || !plan[r - 1].is_cfg) drain();
        write_reg(plan[r].reg_idx, plan[r].reg_val, (r + 1 < PLAN_ROWS) && plan[r + 1].is_cfg);
      end else begin
        offer(plan[r].beat, plan[r].fixed, plan[r].reply);
      end
    end

    // random phases, the first four at the register extremes
    phase        = 0;
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      drain();
      case (phase)
        0: begin pop_val = 8'd0;   len_val = 8'd0;  end
        1: begin pop_val = 8'd255; len_val = 8'd31; end
        2: begin pop_val = 8'd128; len_val = 8'hF0; end
        3: begin pop_val = 8'd1;   len_val = 8'd1;  end
        default: begin
          // small populations keep breeds short
          pop_val = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 64))
                                                : 8'($urandom_range(2, 12));
          len_val = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
        end
      endcase
      // every fourth phase runs with no gaps and no stalls
      idle_on = (phase % 4) != 3;
      write_reg(CFG_POP_COUNT, pop_val, 1'b1);
      write_reg(CFG_GENE_LEN, len_val, phase == 2);
      if (phase == 2) write_reg(CFG_SPARE, 8'($urandom), 1'b0);
      quota = (live_slots() > 64) ? 170 : $urandom_range(40, 120);
      repeat (quota) begin
        // now and then hold off until the engine has emptied out
        if ($urandom_range(0, 99) == 0) drain();
        b = plan_next_beat();
        offer(b, 1'b0, '0);
        if (b.op != OP_NONE) random_beats++;
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0) $display("genetic_algorithm_generation_engine: match");
    else $display("genetic_algorithm_generation_engine: mismatch");
    $finish;
  end

endmodule
